>>> rtl/core/wsps_pkg.sv
package wsps_pkg;

  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned PCM_W      = 16;
  localparam int unsigned BC_W       = 5;
  localparam int unsigned OUT_DATA_W = 112;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd26214;
  localparam logic [GAIN_W:0]   GAIN_UNITY = 17'd32768;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  typedef enum logic [3:0] {
    PH_RIFF      = 4'd0,
    PH_SIZE      = 4'd1,
    PH_WAVE      = 4'd2,
    PH_FMT_HDR   = 4'd3,
    PH_FMT_BODY  = 4'd4,
    PH_FMT_SKIP  = 4'd5,
    PH_DATA_HDR  = 4'd6,
    PH_DATA_SKIP = 4'd7,
    PH_SAMPLES   = 4'd8,
    PH_DRAIN     = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_SAMPLE  = 3'd1,
    KIND_NO_RIFF = 3'd2,
    KIND_NO_WAVE = 3'd3,
    KIND_NO_DATA = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] pcm;
    logic [31:0] rate_hz;
    logic [15:0] bit_depth;
    logic [15:0] channel_count;
    logic [31:0] data_len;
    logic        last_sample;
  } res_t;

endpackage

>>> rtl/core/wsps_parse.sv
module wsps_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          end_of_file,
  output logic          res_valid,
  input  logic          res_ready,
  output wsps_pkg::res_t res
);

  wsps_pkg::phase_t         phase_r, phase_nxt;
  logic [wsps_pkg::BC_W-1:0] bc_r, bc_nxt;
  logic [31:0]              tag_r, tag_nxt;
  logic [31:0]              len_r, len_nxt;
  logic [31:0]              rate_r, rate_nxt;
  logic [15:0]              width_r, width_nxt;
  logic [15:0]              chans_r, chans_nxt;
  logic [31:0]              left_r, left_nxt;
  logic [7:0]               low_r, low_nxt;
  logic                     res_v_r, res_v_nxt;
  wsps_pkg::res_t           res_r, res_nxt;
  logic                     hit;
  logic                     take;

  assign in_ready  = !res_v_r || res_ready;
  assign take      = in_valid && in_ready;
  assign res_valid = res_v_r;
  assign res       = res_r;

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    rate_nxt  = rate_r;
    width_nxt = width_r;
    chans_nxt = chans_r;
    left_nxt  = left_r;
    low_nxt   = low_r;
    res_nxt   = '0;
    hit       = 1'b0;

    case (phase_r)
      wsps_pkg::PH_RIFF, wsps_pkg::PH_WAVE: begin
        tag_nxt = {tag_r[23:0], data_byte};
        bc_nxt  = bc_r + 1'b1;
        if (bc_r == 5'd3) begin
          if (phase_r == wsps_pkg::PH_RIFF) begin
            if (tag_nxt == wsps_pkg::TAG_RIFF) begin
              phase_nxt = wsps_pkg::PH_SIZE;
              bc_nxt    = '0;
              tag_nxt   = '0;
              len_nxt   = '0;
            end else begin
              res_nxt.kind = wsps_pkg::KIND_NO_RIFF;
              hit          = 1'b1;
              phase_nxt    = wsps_pkg::PH_DRAIN;
            end
          end else begin
            if (tag_nxt == wsps_pkg::TAG_WAVE) begin
              phase_nxt = wsps_pkg::PH_FMT_HDR;
              bc_nxt    = '0;
              tag_nxt   = '0;
              len_nxt   = '0;
            end else begin
              res_nxt.kind = wsps_pkg::KIND_NO_WAVE;
              hit          = 1'b1;
              phase_nxt    = wsps_pkg::PH_DRAIN;
            end
          end
        end
      end
      wsps_pkg::PH_SIZE: begin
        bc_nxt = bc_r + 1'b1;
        if (bc_r >= 5'd3) begin
          phase_nxt = wsps_pkg::PH_WAVE;
          bc_nxt    = '0;
          tag_nxt   = '0;
          len_nxt   = '0;
        end
      end
      wsps_pkg::PH_FMT_HDR, wsps_pkg::PH_DATA_HDR: begin
        // tag bytes arrive big-end first, length little-endian
        if (bc_r < 5'd4) begin
          tag_nxt = {tag_r[23:0], data_byte};
        end else begin
          len_nxt = len_r | ({24'd0, data_byte} << {bc_r[1:0], 3'b000});
        end
        bc_nxt = bc_r + 1'b1;
        if (bc_r >= 5'd7) begin
          bc_nxt = '0;
          if (phase_r == wsps_pkg::PH_FMT_HDR && tag_r == wsps_pkg::TAG_FMT) begin
            phase_nxt = wsps_pkg::PH_FMT_BODY;
          end else if (phase_r == wsps_pkg::PH_DATA_HDR && tag_r == wsps_pkg::TAG_DATA) begin
            res_nxt.kind          = wsps_pkg::KIND_HEADER;
            res_nxt.rate_hz       = rate_r;
            res_nxt.bit_depth     = width_r;
            res_nxt.channel_count = chans_r;
            res_nxt.data_len      = len_nxt;
            hit                   = 1'b1;
            left_nxt              = len_nxt;
            phase_nxt = (len_nxt != 32'd0) ? wsps_pkg::PH_SAMPLES : wsps_pkg::PH_DRAIN;
          end else if (len_nxt == 32'd0) begin
            tag_nxt = '0;
            len_nxt = '0;
          end else begin
            phase_nxt = (phase_r == wsps_pkg::PH_FMT_HDR) ? wsps_pkg::PH_FMT_SKIP
                                                           : wsps_pkg::PH_DATA_SKIP;
          end
        end
      end
      wsps_pkg::PH_FMT_SKIP, wsps_pkg::PH_DATA_SKIP: begin
        len_nxt = len_r - 32'd1;
        if (len_r == 32'd1) begin
          phase_nxt = (phase_r == wsps_pkg::PH_FMT_SKIP) ? wsps_pkg::PH_FMT_HDR
                                                          : wsps_pkg::PH_DATA_HDR;
          bc_nxt    = '0;
          tag_nxt   = '0;
          len_nxt   = '0;
        end
      end
      wsps_pkg::PH_FMT_BODY: begin
        if (bc_r == 5'd2 || bc_r == 5'd3) begin
          chans_nxt = chans_r | ({8'd0, data_byte} << {bc_r[0], 3'b000});
        end else if (bc_r >= 5'd4 && bc_r <= 5'd7) begin
          rate_nxt = rate_r | ({24'd0, data_byte} << {bc_r[1:0], 3'b000});
        end else if (bc_r == 5'd14 || bc_r == 5'd15) begin
          width_nxt = width_r | ({8'd0, data_byte} << {bc_r[0], 3'b000});
        end
        bc_nxt = bc_r + 1'b1;
        if (bc_r >= 5'd15) begin
          // fmt bodies longer than 16 bytes skip the rest
          if (len_r > 32'd16) begin
            len_nxt   = len_r - 32'd16;
            bc_nxt    = '0;
            phase_nxt = wsps_pkg::PH_DATA_SKIP;
          end else begin
            phase_nxt = wsps_pkg::PH_DATA_HDR;
            bc_nxt    = '0;
            tag_nxt   = '0;
            len_nxt   = '0;
          end
        end
      end
      wsps_pkg::PH_SAMPLES: begin
        left_nxt = left_r - 32'd1;
        if (bc_r == 5'd0) begin
          low_nxt = data_byte;
          bc_nxt  = 5'd1;
        end else begin
          res_nxt.kind        = wsps_pkg::KIND_SAMPLE;
          res_nxt.pcm         = {data_byte, low_r};
          res_nxt.last_sample = (left_nxt == 32'd0) || end_of_file;
          hit                 = 1'b1;
          bc_nxt              = '0;
        end
        if (left_nxt == 32'd0) begin
          phase_nxt = wsps_pkg::PH_DRAIN;
        end
      end
      default: begin
      end
    endcase

    if (end_of_file) begin
      if (!hit) begin
        case (phase_nxt)
          wsps_pkg::PH_RIFF: begin
            res_nxt.kind = wsps_pkg::KIND_NO_RIFF;
            hit          = 1'b1;
          end
          wsps_pkg::PH_SIZE, wsps_pkg::PH_WAVE: begin
            res_nxt.kind = wsps_pkg::KIND_NO_WAVE;
            hit          = 1'b1;
          end
          wsps_pkg::PH_FMT_HDR, wsps_pkg::PH_FMT_BODY, wsps_pkg::PH_FMT_SKIP,
          wsps_pkg::PH_DATA_HDR, wsps_pkg::PH_DATA_SKIP: begin
            res_nxt.kind = wsps_pkg::KIND_NO_DATA;
            hit          = 1'b1;
          end
          default: begin
          end
        endcase
      end
      phase_nxt = wsps_pkg::PH_RIFF;
      bc_nxt    = '0;
      tag_nxt   = '0;
      len_nxt   = '0;
      rate_nxt  = '0;
      width_nxt = '0;
      chans_nxt = '0;
      left_nxt  = '0;
      low_nxt   = '0;
    end
  end

  always_comb begin
    if (take) begin
      res_v_nxt = hit;
    end else if (res_ready) begin
      res_v_nxt = 1'b0;
    end else begin
      res_v_nxt = res_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsps_pkg::PH_RIFF;
      bc_r    <= '0;
      tag_r   <= '0;
      len_r   <= '0;
      rate_r  <= '0;
      width_r <= '0;
      chans_r <= '0;
      left_r  <= '0;
      low_r   <= '0;
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= res_v_nxt;
      if (take) begin
        phase_r <= phase_nxt;
        bc_r    <= bc_nxt;
        tag_r   <= tag_nxt;
        len_r   <= len_nxt;
        rate_r  <= rate_nxt;
        width_r <= width_nxt;
        chans_r <= chans_nxt;
        left_r  <= left_nxt;
        low_r   <= low_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> rtl/core/wsps_scale.sv
module wsps_scale (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [wsps_pkg::GAIN_W-1:0]     gain,
  input  logic                            res_valid,
  output logic                            res_ready,
  input  wsps_pkg::res_t                  res,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wsps_pkg::OUT_DATA_W-1:0] out_data,
  output logic [2:0]                      out_kind,
  output logic                            out_last
);

  logic                            out_v_r;
  logic [wsps_pkg::OUT_DATA_W-1:0] data_r, data_nxt;
  logic [2:0]                      kind_r;
  logic                            last_r;
  logic [wsps_pkg::GAIN_W:0]       gain_c;
  logic signed [33:0]              prod;
  logic signed [33:0]              prod_adj;
  logic [15:0]                     scaled;
  logic                            take;

  assign res_ready = !out_v_r || out_ready;
  assign take      = res_valid && res_ready;

  // gain above unity saturates at unity
  assign gain_c = ({1'b0, gain} > wsps_pkg::GAIN_UNITY) ? wsps_pkg::GAIN_UNITY
                                                       : {1'b0, gain};

  always_comb begin
    prod     = $signed(res.pcm) * $signed({1'b0, gain_c});
    // bias negative products so the shift truncates toward zero
    prod_adj = prod[33] ? (prod + 34'sd32767) : prod;
    scaled   = prod_adj[30:15];
    data_nxt = {res.data_len, res.channel_count, res.bit_depth, res.rate_hz,
                (res.kind == wsps_pkg::KIND_SAMPLE) ? scaled : 16'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (take) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
      kind_r <= res.kind;
      last_r <= res.last_sample;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = data_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

endmodule

>>> rtl/core/wav_stream_parse_and_scale.sv
// path: the request that a byte causes passes the parser register, then the output register,
// before out_tvalid rises and the request can be accepted
// throughput: one byte per cycle; the parser register and the output register each
// take a new request while the one ahead of them leaves, so stalls only come from out_tready
// reset: synchronous active-low rst_n returns the parser to the riff tag, empties both
// registers and sets the gain to 26214 (0.8); end of file also restarts the parser
module wav_stream_parse_and_scale (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // end_of_file
  output logic         out_tvalid,
  input  logic         out_tready,
  // sample, rate_hz, bit_depth, channel_count, data_len
  output logic [111:0] out_tdata,
  output logic [2:0]   out_tuser,  // kind
  output logic         out_tlast,  // last_sample
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data    // volume_gain
);

  logic [wsps_pkg::GAIN_W-1:0] gain_r;
  logic                        res_valid;
  logic                        res_ready;
  wsps_pkg::res_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= wsps_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      gain_r <= cfg_data;
    end
  end

  wsps_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .data_byte   (in_tdata),
    .end_of_file (in_tlast),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  wsps_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (gain_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

>>> rtl/core/wsps_check.sv
module wsps_check (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  // a stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output request changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != wsps_pkg::KIND_SAMPLE |-> out_tdata[15:0] == 16'd0 && !out_tlast)
    else $error("sample field or last set on a non-sample request");

  a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != wsps_pkg::KIND_HEADER |-> out_tdata[111:16] == 96'd0)
    else $error("header fields set on a non-header request");

endmodule

bind wav_stream_parse_and_scale wsps_check u_wsps_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
